@@ rtl/core/sbsh_pkg.sv @@
package sbsh_pkg;

   // geometry of one message block
   localparam int BLOCK_BYTES = 64;
   localparam int BLOCK_WORDS = 16;
   localparam int HASH_WORDS  = 8;
   localparam int ROUNDS      = 64;

   // padding constants
   localparam logic [7:0]  PAD_MARK   = 8'h80;
   localparam logic [5:0]  LEN_POS    = 6'd56;
   localparam logic [63:0] BLOCK_BITS = 64'd512;

   // initial hash values
   localparam logic [31:0] INIT_HASH [0:HASH_WORDS-1] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   // round constants
   localparam logic [31:0] ROUND_K [0:ROUNDS-1] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   // controls from the sequencer to the round datapath
   typedef struct packed {
      logic       w_load;
      logic       h_load;
      logic       round_en;
      logic       upd_rot;
      logic [5:0] round_idx;
   } round_ctl_type;

endpackage

@@ rtl/core/sbsh_block_ram.sv @@
module sbsh_block_ram (
   input  logic        clock,
   input  logic        wr_en,
   input  logic [5:0]  wr_addr,
   input  logic [7:0]  wr_byte,
   input  logic        rd_en,
   input  logic [3:0]  rd_addr,
   output logic [31:0] rd_data
);

   logic [31:0] mem [0:sbsh_pkg::BLOCK_WORDS-1];
   logic [31:0] rd_data_ff;
   logic [1:0]  lane;

   // big-endian byte lane inside a word
   assign lane = 2'd3 - wr_addr[1:0];

   // byte write, registered word read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr[5:2]][{lane, 3'b000} +: 8] <= wr_byte;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/sbsh_hash_ram.sv @@
module sbsh_hash_ram (
   input  logic        clock,
   input  logic        reset,
   input  logic        clear,
   input  logic        rd_en,
   input  logic [2:0]  rd_addr,
   output logic [31:0] rd_data,
   input  logic        wr_en,
   input  logic [2:0]  wr_addr,
   input  logic [31:0] wr_data
);

   logic [31:0] mem [0:sbsh_pkg::HASH_WORDS-1];
   logic [7:0]  valid_ff;
   logic [7:0]  valid_in;
   logic [31:0] rd_word_ff;
   logic        rd_valid_ff;
   logic [2:0]  rd_addr_ff;

   // valid bits: an entry not yet written reads as its initial value
   always_comb begin
      valid_in = valid_ff;
      if (clear) begin
         valid_in = '0;
      end else if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // storage and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_word_ff  <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
         rd_addr_ff  <= rd_addr;
      end
   end

   assign rd_data = rd_valid_ff ? rd_word_ff : sbsh_pkg::INIT_HASH[rd_addr_ff];

endmodule

@@ rtl/core/sbsh_round.sv @@
module sbsh_round (
   input  logic                    clock,
   input  sbsh_pkg::round_ctl_type ctl,
   input  logic [31:0]             w_data,
   input  logic [31:0]             h_data,
   output logic [31:0]             work_head
);

   logic [31:0] w_ff    [0:15];
   logic [31:0] w_in    [0:15];
   logic [31:0] work_ff [0:7];
   logic [31:0] work_in [0:7];
   logic [31:0] w_new;
   logic [31:0] t1;
   logic [31:0] t2;

   function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
      begin
         rotr = (v >> n) | (v << (32 - n));
      end
   endfunction

   // schedule word sixteen ahead of the window head
   assign w_new = (rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10)) +
                  w_ff[9] +
                  (rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3)) +
                  w_ff[0];

   // one compression round
   assign t1 = work_ff[7] +
               (rotr(work_ff[4], 6) ^ rotr(work_ff[4], 11) ^ rotr(work_ff[4], 25)) +
               ((work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6])) +
               sbsh_pkg::ROUND_K[ctl.round_idx] + w_ff[0];
   assign t2 = (rotr(work_ff[0], 2) ^ rotr(work_ff[0], 13) ^ rotr(work_ff[0], 22)) +
               ((work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2]) ^
                (work_ff[1] & work_ff[2]));

   // schedule window: load shifts in block words, rounds shift in new words
   always_comb begin
      w_in = w_ff;
      if (ctl.w_load || ctl.round_en) begin
         for (int j = 0; j < 15; j++) begin
            w_in[j] = w_ff[j + 1];
         end
         w_in[15] = ctl.w_load ? w_data : w_new;
      end
   end

   // working variables a..h
   always_comb begin
      work_in = work_ff;
      if (ctl.h_load) begin
         for (int j = 0; j < 7; j++) begin
            work_in[j] = work_ff[j + 1];
         end
         work_in[7] = h_data;
      end else if (ctl.round_en) begin
         work_in[0] = t1 + t2;
         work_in[1] = work_ff[0];
         work_in[2] = work_ff[1];
         work_in[3] = work_ff[2];
         work_in[4] = work_ff[3] + t1;
         work_in[5] = work_ff[4];
         work_in[6] = work_ff[5];
         work_in[7] = work_ff[6];
      end else if (ctl.upd_rot) begin
         for (int j = 0; j < 7; j++) begin
            work_in[j] = work_ff[j + 1];
         end
         work_in[7] = work_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      w_ff    <= w_in;
      work_ff <= work_in;
   end

   assign work_head = work_ff[0];

endmodule

@@ rtl/core/sha256_byte_stream_hasher.sv @@
// A byte that does not complete a block is stored and the hasher stays ready; a byte that
// completes a block starts a compression (accept, load, rounds, hash update), paced by the
// one-round-per-cycle datapath and the byte-wide block and word-wide hash stores. End of
// message: accept, pad to the end of the block, compress, pad and compress a second block
// if the length did not fit, then send each digest word (read, load, hold until taken).
// Reset is synchronous; it clears the hash store valid bits so it reads initial values.
module sha256_byte_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_LOAD     = 3'd1;
   localparam logic [2:0] S_ROUND    = 3'd2;
   localparam logic [2:0] S_UPDATE   = 3'd3;
   localparam logic [2:0] S_PAD      = 3'd4;
   localparam logic [2:0] S_OUT_RD   = 3'd5;
   localparam logic [2:0] S_OUT_LD   = 3'd6;
   localparam logic [2:0] S_OUT_HOLD = 3'd7;

   localparam logic [5:0] LOAD_LAST  = 6'd16;
   localparam logic [5:0] ROUND_LAST = 6'd63;
   localparam logic [5:0] UPD_LAST   = 6'd8;
   localparam logic [5:0] BYTE_LAST  = 6'd63;
   localparam logic [2:0] WORD_LAST  = 3'd7;

   logic [2:0]  state_ff, state_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] count_ff, count_in;
   logic        eom_ff, eom_in;
   logic        fin_ff, fin_in;
   logic        extra_ff, extra_in;
   logic        mark_ff, mark_in;
   logic [5:0]  ptr_ff, ptr_in;
   logic [2:0]  out_idx_ff, out_idx_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_word_ff, rsp_word_in;

   logic        accept;
   logic [5:0]  fill_next;
   logic [63:0] total_bits;
   logic [2:0]  len_lane;

   logic        blk_wr_en;
   logic [5:0]  blk_wr_addr;
   logic [7:0]  blk_wr_byte;
   logic        blk_rd_en;
   logic [3:0]  blk_rd_addr;
   logic [31:0] blk_rd_data;

   logic        hash_clear;
   logic        hash_rd_en;
   logic [2:0]  hash_rd_addr;
   logic [31:0] hash_q;
   logic        hash_wr_en;
   logic [2:0]  hash_wr_addr;
   logic [31:0] hash_wr_data;
   logic [31:0] work_head;

   sbsh_pkg::round_ctl_type round_ctl;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign fill_next = fill_ff + 6'd1;

   // message length in bits, taken apart big-endian for the length field
   assign total_bits = count_ff + {55'd0, fill_ff, 3'b000};
   assign len_lane   = 3'd7 - ptr_ff[2:0];

   assign hash_wr_data = hash_q + work_head;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      fill_in      = fill_ff;
      count_in     = count_ff;
      eom_in       = eom_ff;
      fin_in       = fin_ff;
      extra_in     = extra_ff;
      mark_in      = mark_ff;
      ptr_in       = ptr_ff;
      out_idx_in   = out_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      blk_wr_en    = 1'b0;
      blk_wr_addr  = ptr_ff;
      blk_wr_byte  = '0;
      blk_rd_en    = 1'b0;
      blk_rd_addr  = cnt_ff[3:0];
      hash_clear   = 1'b0;
      hash_rd_en   = 1'b0;
      hash_rd_addr = cnt_ff[2:0];
      hash_wr_en   = 1'b0;
      hash_wr_addr = cnt_ff[2:0] - 3'd1;
      round_ctl    = '0;
      round_ctl.round_idx = cnt_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_byte_present) begin
                  blk_wr_en   = 1'b1;
                  blk_wr_addr = fill_ff;
                  blk_wr_byte = req_data_byte;
               end
               if (req_byte_present && fill_ff == BYTE_LAST) begin
                  // block full: compress, finish the message afterwards if asked
                  fill_in  = '0;
                  count_in = count_ff + sbsh_pkg::BLOCK_BITS;
                  eom_in   = req_end_of_message;
                  fin_in   = 1'b0;
                  cnt_in   = '0;
                  state_in = S_LOAD;
               end else begin
                  if (req_byte_present) begin
                     fill_in = fill_next;
                  end
                  if (req_end_of_message) begin
                     ptr_in   = req_byte_present ? fill_next : fill_ff;
                     mark_in  = 1'b1;
                     extra_in = req_byte_present ? (fill_next >= sbsh_pkg::LEN_POS)
                                                 : (fill_ff >= sbsh_pkg::LEN_POS);
                     state_in = S_PAD;
                  end
               end
            end
         end

         S_LOAD: begin
            blk_rd_en  = (cnt_ff < LOAD_LAST);
            hash_rd_en = (cnt_ff < UPD_LAST);
            round_ctl.w_load = (cnt_ff != '0);
            round_ctl.h_load = (cnt_ff != '0) && (cnt_ff <= UPD_LAST);
            if (cnt_ff == LOAD_LAST) begin
               cnt_in   = '0;
               state_in = S_ROUND;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end

         S_ROUND: begin
            round_ctl.round_en = 1'b1;
            if (cnt_ff == ROUND_LAST) begin
               cnt_in   = '0;
               state_in = S_UPDATE;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end

         S_UPDATE: begin
            // read word k while word k-1 is written back
            hash_rd_en = (cnt_ff < UPD_LAST);
            if (cnt_ff != '0) begin
               hash_wr_en        = 1'b1;
               round_ctl.upd_rot = 1'b1;
            end
            if (cnt_ff == UPD_LAST) begin
               cnt_in = '0;
               if (!fin_ff) begin
                  if (eom_ff) begin
                     ptr_in   = fill_ff;
                     mark_in  = 1'b1;
                     extra_in = 1'b0;
                     state_in = S_PAD;
                  end else begin
                     state_in = S_IDLE;
                  end
               end else if (extra_ff) begin
                  // length did not fit: pad a second block
                  extra_in = 1'b0;
                  ptr_in   = '0;
                  fin_in   = 1'b0;
                  state_in = S_PAD;
               end else begin
                  out_idx_in = '0;
                  state_in   = S_OUT_RD;
               end
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end

         S_PAD: begin
            blk_wr_en   = 1'b1;
            blk_wr_addr = ptr_ff;
            if (mark_ff) begin
               blk_wr_byte = sbsh_pkg::PAD_MARK;
            end else if (!extra_ff && ptr_ff >= sbsh_pkg::LEN_POS) begin
               blk_wr_byte = total_bits[{len_lane, 3'b000} +: 8];
            end else begin
               blk_wr_byte = '0;
            end
            mark_in = 1'b0;
            if (ptr_ff == BYTE_LAST) begin
               ptr_in   = '0;
               fin_in   = 1'b1;
               cnt_in   = '0;
               state_in = S_LOAD;
            end else begin
               ptr_in = ptr_ff + 6'd1;
            end
         end

         S_OUT_RD: begin
            hash_rd_en   = 1'b1;
            hash_rd_addr = out_idx_ff;
            state_in     = S_OUT_LD;
         end

         S_OUT_LD: begin
            rsp_word_in  = hash_q;
            rsp_valid_in = 1'b1;
            state_in     = S_OUT_HOLD;
         end

         S_OUT_HOLD: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (out_idx_ff == WORD_LAST) begin
                  // digest delivered: back to the initial state
                  hash_clear = 1'b1;
                  fill_in    = '0;
                  count_in   = '0;
                  eom_in     = 1'b0;
                  fin_in     = 1'b0;
                  extra_in   = 1'b0;
                  out_idx_in = '0;
                  state_in   = S_IDLE;
               end else begin
                  out_idx_in = out_idx_ff + 3'd1;
                  state_in   = S_OUT_RD;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         fill_ff      <= '0;
         count_ff     <= '0;
         eom_ff       <= 1'b0;
         fin_ff       <= 1'b0;
         extra_ff     <= 1'b0;
         mark_ff      <= 1'b0;
         ptr_ff       <= '0;
         out_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         fill_ff      <= fill_in;
         count_ff     <= count_in;
         eom_ff       <= eom_in;
         fin_ff       <= fin_in;
         extra_ff     <= extra_in;
         mark_ff      <= mark_in;
         ptr_ff       <= ptr_in;
         out_idx_ff   <= out_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   sbsh_block_ram u_block_ram (
      .clock   (clock),
      .wr_en   (blk_wr_en),
      .wr_addr (blk_wr_addr),
      .wr_byte (blk_wr_byte),
      .rd_en   (blk_rd_en),
      .rd_addr (blk_rd_addr),
      .rd_data (blk_rd_data)
   );

   sbsh_hash_ram u_hash_ram (
      .clock   (clock),
      .reset   (reset),
      .clear   (hash_clear),
      .rd_en   (hash_rd_en),
      .rd_addr (hash_rd_addr),
      .rd_data (hash_q),
      .wr_en   (hash_wr_en),
      .wr_addr (hash_wr_addr),
      .wr_data (hash_wr_data)
   );

   sbsh_round u_round (
      .clock     (clock),
      .ctl       (round_ctl),
      .w_data    (blk_rd_data),
      .h_data    (hash_q),
      .work_head (work_head)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_digest_word = rsp_word_ff;
   assign rsp_word_index  = out_idx_ff;
   assign rsp_last_word   = (out_idx_ff == WORD_LAST);

`ifndef SYNTH
   a_hash_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (hash_wr_en && hash_rd_en) |-> (hash_wr_addr != hash_rd_addr))
      else $error("hash store read and write hit the same entry");

   a_rsp_in_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == S_OUT_HOLD))
      else $error("result valid outside the output hold state");

   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_word) |=>
      (state_ff == S_IDLE && fill_ff == '0 && count_ff == '0 && !eom_ff))
      else $error("hasher not back to initial state after last digest word");

   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_OUT_LD))
      else $error("result raised without a hash store read");
`endif

endmodule
